>>> src/assert_macros.svh
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BPF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define BPF_ASSERT(lbl, prop, msg)

`define BPF_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

>>> src/bpf_pkg.sv
package bpf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MODE_W     = 3;
  localparam int FAULT_W    = 5;

  localparam logic [MODE_W-1:0] MODE_INIT        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STANDBY     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLEEP       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHARGING    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DISCHARGING = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FAULT       = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_HI      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LO      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_CURR_LIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIS_CURR_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HI      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LO      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY  = 3'd6;

  localparam int FB_OVERVOLT  = 0;
  localparam int FB_UNDERVOLT = 1;
  localparam int FB_OVERCURR  = 2;
  localparam int FB_OVERTEMP  = 3;
  localparam int FB_UNDERTEMP = 4;

  localparam logic [15:0]        RST_VOLT_HI      = 16'd16800;
  localparam logic [15:0]        RST_VOLT_LO      = 16'd12000;
  localparam logic [15:0]        RST_CHG_CURR_LIM = 16'd5000;
  localparam logic [15:0]        RST_DIS_CURR_LIM = 16'd20000;
  localparam logic signed [15:0] RST_TEMP_HI      = 16'sd600;
  localparam logic signed [15:0] RST_TEMP_LO      = -16'sd200;
  localparam logic [31:0]        RST_SLEEP_DELAY  = 32'd60000;

  typedef struct packed {
    logic [15:0]        pack_voltage;
    logic [15:0]        pack_current;
    logic signed [15:0] pack_temperature;
    logic               charger_present;
    logic               light_load;
    logic               wake_req;
    logic               clear_fault;
    logic [15:0]        elapsed_ms;
  } in_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               charge_on;
    logic               discharge_on;
    logic               fault_on;
    logic [FAULT_W-1:0] fault_bits;
  } out_t;

  typedef struct packed {
    logic [15:0]        volt_hi;
    logic [15:0]        volt_lo;
    logic [15:0]        chg_curr_lim;
    logic [15:0]        dis_curr_lim;
    logic signed [15:0] temp_hi;
    logic signed [15:0] temp_lo;
  } limits_t;

endpackage

>>> src/bpf_fault_check.sv
module bpf_fault_check
  import bpf_pkg::*;
(
  input  in_t                 sample,
  input  limits_t             limits,
  output logic [FAULT_W-1:0]  fault_bits
);

  logic [15:0] curr_limit;

  assign curr_limit = sample.charger_present ? limits.chg_curr_lim
                                             : limits.dis_curr_lim;

  always_comb begin
    fault_bits               = '0;
    fault_bits[FB_OVERVOLT]  = sample.pack_voltage > limits.volt_hi;
    fault_bits[FB_UNDERVOLT] = sample.pack_voltage < limits.volt_lo;
    fault_bits[FB_OVERCURR]  = sample.pack_current > curr_limit;
    fault_bits[FB_OVERTEMP]  = sample.pack_temperature > limits.temp_hi;
    fault_bits[FB_UNDERTEMP] = sample.pack_temperature < limits.temp_lo;
  end

endmodule

>>> src/battery_protection_fsm.sv
// Battery protection controller. Each input beat is one periodic sample; each produces
// exactly one output beat carrying the mode, path enables, fault flag and fault bits as
// they stand after that sample. One sample per clock is sustained while out_ready is
// high: a sample is first captured in an input register, then the limit compares and
// the state machine update run combinationally into the state registers, which drive
// the output directly, so a result is presented once its sample has passed the input
// register and the state update. While out_ready is low one more sample is taken, then
// in_ready drops. Limit registers reset to their defaults; the user must write them
// through the cfg_ port only while no sample is in flight; the block does not check.
`include "assert_macros.svh"

module battery_protection_fsm
  import bpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,

  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  limits_t                limits_r;
  logic [31:0]            sleep_delay_r;

  in_t                    s1_data_r;
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic                   s1_adv;
  logic                   in_fire;
  logic                   out_valid_r;
  logic                   out_valid_nxt;

  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic                   charge_r, charge_nxt;
  logic                   discharge_r, discharge_nxt;
  logic                   fault_active_r, fault_active_nxt;
  logic [FAULT_W-1:0]     fault_bits_r, fault_bits_nxt;
  logic [31:0]            idle_timer_r, idle_timer_nxt;

  logic [FAULT_W-1:0]     sample_faults;
  logic [32:0]            idle_sum;
  logic [31:0]            idle_sat;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.volt_hi      <= RST_VOLT_HI;
      limits_r.volt_lo      <= RST_VOLT_LO;
      limits_r.chg_curr_lim <= RST_CHG_CURR_LIM;
      limits_r.dis_curr_lim <= RST_DIS_CURR_LIM;
      limits_r.temp_hi      <= RST_TEMP_HI;
      limits_r.temp_lo      <= RST_TEMP_LO;
      sleep_delay_r         <= RST_SLEEP_DELAY;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_VOLT_HI:      limits_r.volt_hi      <= cfg_wdata[15:0];
        CFG_VOLT_LO:      limits_r.volt_lo      <= cfg_wdata[15:0];
        CFG_CHG_CURR_LIM: limits_r.chg_curr_lim <= cfg_wdata[15:0];
        CFG_DIS_CURR_LIM: limits_r.dis_curr_lim <= cfg_wdata[15:0];
        CFG_TEMP_HI:      limits_r.temp_hi      <= $signed(cfg_wdata[15:0]);
        CFG_TEMP_LO:      limits_r.temp_lo      <= $signed(cfg_wdata[15:0]);
        CFG_SLEEP_DELAY:  sleep_delay_r         <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // handshake and pipeline control
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || s1_adv;
  assign in_fire       = in_valid && in_ready;
  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
  end

  bpf_fault_check u_fault_check (
    .sample     (s1_data_r),
    .limits     (limits_r),
    .fault_bits (sample_faults)
  );

  // saturating idle timer
  assign idle_sum = {1'b0, idle_timer_r} + {17'd0, s1_data_r.elapsed_ms};
  assign idle_sat = idle_sum[32] ? '1 : idle_sum[31:0];

  always_comb begin
    mode_nxt         = mode_r;
    charge_nxt       = charge_r;
    discharge_nxt    = discharge_r;
    fault_active_nxt = fault_active_r;
    fault_bits_nxt   = fault_bits_r;
    idle_timer_nxt   = idle_timer_r;
    if (sample_faults != '0) begin
      fault_bits_nxt   = sample_faults;
      fault_active_nxt = 1'b1;
      mode_nxt         = MODE_FAULT;
      charge_nxt       = 1'b0;
      discharge_nxt    = 1'b0;
    end else begin
      case (mode_r)
        MODE_INIT: begin
          idle_timer_nxt   = '0;
          mode_nxt         = MODE_STANDBY;
          charge_nxt       = 1'b0;
          discharge_nxt    = 1'b0;
          fault_active_nxt = 1'b0;
          fault_bits_nxt   = '0;
        end
        MODE_STANDBY: begin
          charge_nxt       = 1'b0;
          discharge_nxt    = 1'b0;
          fault_active_nxt = 1'b0;
          if (fault_bits_r != '0) begin
            mode_nxt = MODE_FAULT;
          end else if (s1_data_r.charger_present) begin
            mode_nxt = MODE_CHARGING;
          end else if (s1_data_r.light_load) begin
            idle_timer_nxt = idle_sat;
            if (idle_sat >= sleep_delay_r && !s1_data_r.wake_req) begin
              mode_nxt = MODE_SLEEP;
            end
          end else begin
            mode_nxt = MODE_DISCHARGING;
          end
        end
        MODE_SLEEP: begin
          charge_nxt    = 1'b0;
          discharge_nxt = 1'b0;
          if (s1_data_r.wake_req) begin
            idle_timer_nxt = '0;
            mode_nxt       = MODE_STANDBY;
          end
        end
        MODE_CHARGING: begin
          idle_timer_nxt = '0;
          charge_nxt     = 1'b1;
          discharge_nxt  = 1'b0;
          if (fault_bits_r != '0) begin
            mode_nxt = MODE_FAULT;
          end else if (!s1_data_r.charger_present) begin
            mode_nxt = MODE_STANDBY;
          end
        end
        MODE_DISCHARGING: begin
          idle_timer_nxt = '0;
          charge_nxt     = 1'b0;
          discharge_nxt  = 1'b1;
          if (fault_bits_r != '0) begin
            mode_nxt = MODE_FAULT;
          end else if (s1_data_r.light_load) begin
            mode_nxt = MODE_STANDBY;
          end
        end
        MODE_FAULT: begin
          charge_nxt       = 1'b0;
          discharge_nxt    = 1'b0;
          fault_active_nxt = 1'b1;
          if (s1_data_r.clear_fault) begin
            fault_bits_nxt   = '0;
            fault_active_nxt = 1'b0;
            mode_nxt         = MODE_STANDBY;
            idle_timer_nxt   = '0;
          end
        end
        default: begin
          mode_nxt         = MODE_INIT;
          charge_nxt       = 1'b0;
          discharge_nxt    = 1'b0;
          fault_active_nxt = 1'b0;
          fault_bits_nxt   = '0;
          idle_timer_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_INIT;
      charge_r       <= 1'b0;
      discharge_r    <= 1'b0;
      fault_active_r <= 1'b0;
      fault_bits_r   <= '0;
      idle_timer_r   <= '0;
    end else if (s1_adv) begin
      mode_r         <= mode_nxt;
      charge_r       <= charge_nxt;
      discharge_r    <= discharge_nxt;
      fault_active_r <= fault_active_nxt;
      fault_bits_r   <= fault_bits_nxt;
      idle_timer_r   <= idle_timer_nxt;
    end
  end

  // result beat comes straight from the state registers
  assign out_valid = out_valid_r;
  assign out_data  = '{mode: mode_r, charge_on: charge_r, discharge_on: discharge_r,
                       fault_on: fault_active_r, fault_bits: fault_bits_r};

  `BPF_ASSERT_NEVER(a_both_paths_on, charge_r && discharge_r, "both paths enabled")
  `BPF_ASSERT(a_fault_paths_off, fault_active_r |-> (!charge_r && !discharge_r), "fault path on")
  `BPF_ASSERT(a_bits_in_fault, |fault_bits_r |-> (mode_r == MODE_FAULT), "stray fault bits")
  `BPF_ASSERT(a_sleep_off, (mode_r == MODE_SLEEP) |-> (!charge_r && !discharge_r), "sleep path on")

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import bpf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_BEATS = 200;
  localparam int IDLE_BEATS = 60;
  localparam logic [31:0] IDLE_DELAY = 32'd3997635;

  class bms_scoreboard;
    logic [15:0]        v_hi, v_lo, i_chg, i_dis;
    logic signed [15:0] t_hi, t_lo;
    logic [31:0]        sleep_ms;
    logic [MODE_W-1:0]  mode;
    logic               chg_on, dis_on, flt_on;
    logic [FAULT_W-1:0] flags;
    logic [31:0]        idle_ms;
    out_t               pending_status[$];
    int                 errors;

    function new();
      v_hi = RST_VOLT_HI;
      v_lo = RST_VOLT_LO;
      i_chg = RST_CHG_CURR_LIM;
      i_dis = RST_DIS_CURR_LIM;
      t_hi = RST_TEMP_HI;
      t_lo = RST_TEMP_LO;
      sleep_ms = RST_SLEEP_DELAY;
      mode = MODE_INIT;
      chg_on = 1'b0;
      dis_on = 1'b0;
      flt_on = 1'b0;
      flags = '0;
      idle_ms = '0;
      errors = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_VOLT_HI:      v_hi = d[15:0];
        CFG_VOLT_LO:      v_lo = d[15:0];
        CFG_CHG_CURR_LIM: i_chg = d[15:0];
        CFG_DIS_CURR_LIM: i_dis = d[15:0];
        CFG_TEMP_HI:      t_hi = d[15:0];
        CFG_TEMP_LO:      t_lo = d[15:0];
        CFG_SLEEP_DELAY:  sleep_ms = d;
        default: ;
      endcase
    endfunction

    function void note_sample(in_t s);
      logic [FAULT_W-1:0] fb;
      logic [15:0]        ilim;
      logic [32:0]        sum;
      ilim = s.charger_present ? i_chg : i_dis;
      fb = '0;
      fb[FB_OVERVOLT]  = s.pack_voltage > v_hi;
      fb[FB_UNDERVOLT] = s.pack_voltage < v_lo;
      fb[FB_OVERCURR]  = s.pack_current > ilim;
      fb[FB_OVERTEMP]  = $signed(s.pack_temperature) > t_hi;
      fb[FB_UNDERTEMP] = $signed(s.pack_temperature) < t_lo;
      if (fb != '0) begin
        flags = fb;
        flt_on = 1'b1;
        mode = MODE_FAULT;
        chg_on = 1'b0;
        dis_on = 1'b0;
      end else begin
        case (mode)
          MODE_INIT: begin
            idle_ms = '0;
            mode = MODE_STANDBY;
            chg_on = 1'b0;
            dis_on = 1'b0;
            flt_on = 1'b0;
            flags = '0;
          end
          MODE_STANDBY: begin
            chg_on = 1'b0;
            dis_on = 1'b0;
            flt_on = 1'b0;
            if (flags != '0) begin
              mode = MODE_FAULT;
            end else if (s.charger_present) begin
              mode = MODE_CHARGING;
            end else if (s.light_load) begin
              sum = {1'b0, idle_ms} + {17'd0, s.elapsed_ms};
              idle_ms = sum[32] ? '1 : sum[31:0];
              if (idle_ms >= sleep_ms && !s.wake_req) mode = MODE_SLEEP;
            end else begin
              mode = MODE_DISCHARGING;
            end
          end
          MODE_SLEEP: begin
            chg_on = 1'b0;
            dis_on = 1'b0;
            if (s.wake_req) begin
              idle_ms = '0;
              mode = MODE_STANDBY;
            end
          end
          MODE_CHARGING: begin
            idle_ms = '0;
            chg_on = 1'b1;
            dis_on = 1'b0;
            if (flags != '0) mode = MODE_FAULT;
            else if (!s.charger_present) mode = MODE_STANDBY;
          end
          MODE_DISCHARGING: begin
            idle_ms = '0;
            chg_on = 1'b0;
            dis_on = 1'b1;
            if (flags != '0) mode = MODE_FAULT;
            else if (s.light_load) mode = MODE_STANDBY;
          end
          MODE_FAULT: begin
            chg_on = 1'b0;
            dis_on = 1'b0;
            flt_on = 1'b1;
            if (s.clear_fault) begin
              flags = '0;
              flt_on = 1'b0;
              mode = MODE_STANDBY;
              idle_ms = '0;
            end
          end
          default: begin
            mode = MODE_INIT;
            chg_on = 1'b0;
            dis_on = 1'b0;
            flt_on = 1'b0;
            flags = '0;
            idle_ms = '0;
          end
        endcase
      end
      pending_status.push_back('{mode, chg_on, dis_on, flt_on, flags});
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_status(out_t r);
      out_t e;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected status beat, expected none, actual %0h", $time, r);
        return;
      end
      e = pending_status.pop_front();
      field("mode", 32'(e.mode), 32'(r.mode));
      field("charge_on", 32'(e.charge_on), 32'(r.charge_on));
      field("discharge_on", 32'(e.discharge_on), 32'(r.discharge_on));
      field("fault_on", 32'(e.fault_on), 32'(r.fault_on));
      field("fault_bits", 32'(e.fault_bits), 32'(r.fault_bits));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bms_scoreboard sb;
  logic idling = 1'b1;
  logic sess_chg = 1'b0;
  logic sess_min = 1'b1;
  int   cycle_count = 0;

  battery_protection_fsm uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= !idling || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_status(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_t mk(logic [15:0] volt, logic [15:0] cur, logic [15:0] temp,
                             logic chg, logic minl, logic wake, logic clr,
                             logic [15:0] dt);
    in_t s;
    s.pack_voltage = volt;
    s.pack_current = cur;
    s.pack_temperature = temp;
    s.charger_present = chg;
    s.light_load = minl;
    s.wake_req = wake;
    s.clear_fault = clr;
    s.elapsed_ms = dt;
    return s;
  endfunction

  function automatic in_t make_sample();
    in_t s;
    int lo, hi;
    logic [15:0] ilim;
    if ($urandom_range(99) < 20) sess_chg = ~sess_chg;
    if ($urandom_range(99) < 20) sess_min = ~sess_min;
    s.charger_present = sess_chg;
    s.light_load = sess_min;
    s.wake_req = $urandom_range(99) < 20;
    s.clear_fault = $urandom_range(99) < 30;
    s.elapsed_ms = 16'($urandom_range(1) ? $urandom_range(16'hFFFF) : $urandom_range(2000));
    if ($urandom_range(99) < 12) begin
      // noise beat, any field value
      s.pack_voltage = 16'($urandom_range(16'hFFFF));
      s.pack_current = 16'($urandom_range(16'hFFFF));
      s.pack_temperature = 16'($urandom_range(16'hFFFF));
      s.charger_present = 1'($urandom_range(1));
      s.light_load = 1'($urandom_range(1));
      s.wake_req = 1'($urandom_range(1));
      s.clear_fault = 1'($urandom_range(1));
      s.elapsed_ms = 16'($urandom_range(16'hFFFF));
    end else begin
      s.pack_voltage = (sb.v_lo <= sb.v_hi) ? 16'($urandom_range(sb.v_hi, sb.v_lo))
                                             : 16'($urandom_range(16'hFFFF));
      ilim = s.charger_present ? sb.i_chg : sb.i_dis;
      s.pack_current = 16'($urandom_range(ilim, 0));
      lo = sb.t_lo;
      hi = sb.t_hi;
      if (lo <= hi) s.pack_temperature = 16'(lo + int'($urandom_range(hi - lo, 0)));
      else s.pack_temperature = 16'($urandom_range(16'hFFFF));
    end
    return s;
  endfunction

  task automatic send_sample(in_t s);
    if (idling && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_status.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= d;
    sb.set_limit(idx, d);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // upper bits of the 16 bit registers carry junk that must be dropped
  task automatic configure(logic [15:0] vh, logic [15:0] vl, logic [15:0] ic,
                           logic [15:0] id, logic [15:0] th, logic [15:0] tl,
                           logic [31:0] sd);
    write_reg(CFG_VOLT_HI, {16'($urandom()), vh});
    write_reg(CFG_VOLT_LO, {16'($urandom()), vl});
    write_reg(CFG_CHG_CURR_LIM, {16'($urandom()), ic});
    write_reg(CFG_DIS_CURR_LIM, {16'($urandom()), id});
    write_reg(CFG_TEMP_HI, {16'($urandom()), th});
    write_reg(CFG_TEMP_LO, {16'($urandom()), tl});
    write_reg(CFG_SLEEP_DELAY, sd);
    write_reg(CFG_UNUSED, $urandom());
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // walk the state machine at reset limits
    send_sample(mk(14000, 1000, 250, 0, 1, 0, 0, 10));
    send_sample(mk(14000, 1000, 250, 1, 1, 0, 0, 10));
    send_sample(mk(14000, 1000, 250, 1, 0, 0, 0, 10));
    send_sample(mk(14000, 1000, 250, 0, 0, 0, 0, 10));
    send_sample(mk(14000, 1000, 250, 0, 0, 0, 0, 10));
    send_sample(mk(14000, 1000, 250, 0, 0, 0, 1, 10));
    send_sample(mk(14000, 1000, 250, 0, 1, 0, 0, 10));
    send_sample(mk(14000, 1000, 250, 0, 1, 1, 0, 16'hFFFF));
    send_sample(mk(14000, 1000, 250, 0, 1, 0, 0, 0));
    send_sample(mk(14000, 1000, 250, 1, 0, 0, 0, 5));
    send_sample(mk(14000, 1000, 250, 0, 1, 1, 1, 5));
    send_sample(mk(16800, 20000, 600, 0, 1, 0, 0, 100));
    send_sample(mk(12000, 5000, -200, 1, 1, 0, 0, 100));
    send_sample(mk(14000, 5001, 250, 1, 0, 0, 0, 100));
    send_sample(mk(14000, 1000, 250, 0, 1, 0, 0, 100));
    send_sample(mk(16'hFFFF, 16'hFFFF, 16'sh7FFF, 0, 1, 0, 1, 100));
    send_sample(mk(16'h0000, 16'hFFFF, 16'sh8000, 1, 0, 1, 0, 16'hFFFF));
    send_sample(mk(14000, 1000, 250, 0, 1, 0, 1, 100));
    send_sample(mk(16801, 1000, 250, 0, 1, 0, 0, 100));
    send_sample(mk(14000, 1000, 250, 0, 1, 0, 1, 100));
    send_sample(mk(11999, 1000, 250, 0, 0, 0, 0, 100));
    send_sample(mk(14000, 1000, 601, 0, 1, 0, 1, 100));
    send_sample(mk(14000, 1000, -201, 0, 1, 0, 0, 100));
    send_sample(mk(14000, 20001, 250, 0, 1, 0, 1, 100));
    send_sample(mk(14000, 1000, 250, 0, 1, 0, 1, 100));
    drain();

    // limits wide open, sleep at once
    configure(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000, 32'd0);
    repeat (200) send_sample(make_sample());
    drain();

    // limits closed, every beat faults
    configure(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF);
    repeat (60) send_sample(make_sample());
    drain();

    // idle timer climbs to exactly the sleep delay, then sleeps
    configure(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000, IDLE_DELAY);
    idling = 1'b0;
    send_sample(mk(14000, 1000, 250, 0, 1, 1, 1, 0));
    repeat (IDLE_BEATS) send_sample(mk(14000, 1000, 250, 0, 1, 1, 0, 16'hFFFF));
    send_sample(mk(14000, 1000, 250, 0, 1, 0, 0, 16'hFFFF));
    send_sample(mk(14000, 1000, 250, 0, 1, 1, 0, 0));
    drain();
    idling = 1'b1;

    for (int p = 0; p < RAND_PHASES; p++) begin
      configure(16'($urandom_range(20000, 15000)), 16'($urandom_range(13000, 10000)),
                16'($urandom_range(8000, 1000)), 16'($urandom_range(30000, 5000)),
                16'($urandom_range(800, 300)), 16'(-$signed($urandom_range(400, 0))),
                $urandom_range(150000, 0));
      idling = (p != 3);
      repeat (PHASE_BEATS) send_sample(make_sample());
      drain();
    end

    if (sb.errors == 0 && sb.pending_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> battery_protection_fsm.f
+incdir+src
src/bpf_pkg.sv
src/bpf_fault_check.sv
src/battery_protection_fsm.sv
tb/tb.sv
